// File: src/lecp_pkg.sv
package lecp_pkg;

    localparam int GLYPH_ROWS    = 8;
    localparam int STORE_GLYPHS  = 16;
    localparam int DEFAULT_COUNT = 16;
    localparam int ROW_W         = $clog2(GLYPH_ROWS);
    localparam int SLOT_W        = $clog2(STORE_GLYPHS);
    localparam int ADDR_W        = SLOT_W + ROW_W;
    localparam int STORE_DEPTH   = STORE_GLYPHS * GLYPH_ROWS;

    localparam logic [7:0] ESC_BYTE = 8'h1B;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_C     = 8'h43;
    localparam logic [7:0] CH_X     = 8'h58;
    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_B     = 8'h42;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_L     = 8'h4C;
    localparam logic [7:0] CH_M     = 8'h4D;
    localparam logic [7:0] CH_S     = 8'h53;

    localparam logic [3:0] ACT_CHAR       = 4'd0;
    localparam logic [3:0] ACT_HOME       = 4'd1;
    localparam logic [3:0] ACT_CLEAR      = 4'd2;
    localparam logic [3:0] ACT_OFF        = 4'd3;
    localparam logic [3:0] ACT_ON         = 4'd4;
    localparam logic [3:0] ACT_BLINK      = 4'd5;
    localparam logic [3:0] ACT_CURSOR     = 4'd6;
    localparam logic [3:0] ACT_CUR_BLINK  = 4'd7;
    localparam logic [3:0] ACT_LEFT       = 4'd8;
    localparam logic [3:0] ACT_RIGHT      = 4'd9;
    localparam logic [3:0] ACT_SHL        = 4'd10;
    localparam logic [3:0] ACT_SHR        = 4'd11;
    localparam logic [3:0] ACT_LOCATE     = 4'd12;
    localparam logic [3:0] ACT_GLYPH_ADDR = 4'd13;
    localparam logic [3:0] ACT_GLYPH_ROW  = 4'd14;
    localparam logic [3:0] ACT_SAVED      = 4'd15;

    typedef struct packed {
        logic              res;
        logic              map;
        logic [3:0]        action;
        logic [7:0]        arg_a;
        logic [7:0]        arg_b;
        logic              last;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic              done;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } t_wr;

    localparam logic [7:0] DEFAULT_GLYPHS [DEFAULT_COUNT][8] = '{
        '{8'h00, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h10, 8'h10, 8'h10, 8'h10, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h18, 8'h18, 8'h18, 8'h18, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h1E, 8'h1E, 8'h1E, 8'h1E, 8'h1F, 8'h00},
        '{8'h00, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h1F, 8'h00},
        '{8'h1F, 8'h11, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h1F, 8'h00},
        '{8'h1F, 8'h11, 8'h1F, 8'h11, 8'h1F, 8'h11, 8'h11, 8'h00},
        '{8'h04, 8'h15, 8'h15, 8'h15, 8'h04, 8'h0A, 8'h11, 8'h00},
        '{8'h04, 8'h04, 8'h1D, 8'h06, 8'h0D, 8'h14, 8'h04, 8'h00},
        '{8'h04, 8'h04, 8'h1F, 8'h04, 8'h0E, 8'h15, 8'h04, 8'h00},
        '{8'h04, 8'h0A, 8'h1F, 8'h04, 8'h1F, 8'h0E, 8'h1F, 8'h00},
        '{8'h00, 8'h04, 8'h04, 8'h1F, 8'h04, 8'h04, 8'h1F, 8'h00},
        '{8'h08, 8'h0F, 8'h02, 8'h0F, 8'h0A, 8'h1F, 8'h02, 8'h00},
        '{8'h00, 8'h0E, 8'h15, 8'h15, 8'h15, 8'h0E, 8'h00, 8'h00},
        '{8'h00, 8'h0E, 8'h13, 8'h15, 8'h19, 8'h0E, 8'h00, 8'h00}
    };

    typedef logic [SLOT_W-1:0] t_slot_lut [256];

    // byte to store slot, modulo the store size
    function automatic t_slot_lut f_slot_lut();
        t_slot_lut lut;
        for (int i = 0; i < 256; i++) begin
            lut[i] = SLOT_W'(i % STORE_GLYPHS);
        end
        return lut;
    endfunction

    localparam t_slot_lut SLOT_LUT = f_slot_lut();

    function automatic logic [7:0] f_default_row(input logic [SLOT_W-1:0] slot,
                                                 input logic [ROW_W-1:0]  row);
        logic [7:0] s;
        s = 8'(slot);
        if (s < 8'(DEFAULT_COUNT)) begin
            return DEFAULT_GLYPHS[s[3:0]][row];
        end
        return 8'h00;
    endfunction

endpackage

// File: src/lecp_glyph_ram.sv
module lecp_glyph_ram (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lecp_pkg::t_wr               i_wr,
    input  logic                        i_rd_en,
    input  logic [lecp_pkg::ADDR_W-1:0] i_rd_addr,
    output logic [7:0]                  o_rd_data
);
    import lecp_pkg::*;

    logic [7:0]              mem [STORE_DEPTH];
    logic [STORE_GLYPHS-1:0] r_glyph_ok;
    logic [7:0]              r_rd_data;
    logic [7:0]              r_rd_dflt;
    logic                    r_rd_ok;
    logic [SLOT_W-1:0]       rd_slot;
    logic [SLOT_W-1:0]       wr_slot;

    assign rd_slot = i_rd_addr[ADDR_W-1:ROW_W];
    assign wr_slot = i_wr.addr[ADDR_W-1:ROW_W];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
            r_rd_dflt <= f_default_row(rd_slot, i_rd_addr[ROW_W-1:0]);
            r_rd_ok   <= r_glyph_ok[rd_slot];
        end
    end

    // a slot reads its default glyph until a save completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_ok <= '0;
        end else if (i_wr.en && i_wr.done) begin
            r_glyph_ok[wr_slot] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : r_rd_dflt;

endmodule

// File: src/lecp_parser.sv
module lecp_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_rx_byte,
    output lecp_pkg::t_cmd o_cmd,
    output lecp_pkg::t_wr  o_wr
);
    import lecp_pkg::*;

    localparam logic [3:0] PH_TEXT      = 4'd0;
    localparam logic [3:0] PH_LETTER    = 4'd1;
    localparam logic [3:0] PH_LOC_X     = 4'd2;
    localparam logic [3:0] PH_LOC_Y     = 4'd3;
    localparam logic [3:0] PH_MAP_N     = 4'd4;
    localparam logic [3:0] PH_MAP_K     = 4'd5;
    localparam logic [3:0] PH_SAVE_N    = 4'd6;
    localparam logic [3:0] PH_SAVE_ROW0 = 4'd7;
    localparam logic [3:0] PH_SAVE_ROW1 = 4'd8;
    localparam logic [3:0] PH_SAVE_ROW2 = 4'd9;
    localparam logic [3:0] PH_SAVE_ROW3 = 4'd10;
    localparam logic [3:0] PH_SAVE_ROW4 = 4'd11;
    localparam logic [3:0] PH_SAVE_ROW5 = 4'd12;
    localparam logic [3:0] PH_SAVE_ROW6 = 4'd13;
    localparam logic [3:0] PH_SAVE_ROW7 = 4'd14;

    logic [3:0]        r_phase;
    logic [3:0]        n_phase;
    logic [7:0]        r_first_arg;
    logic [7:0]        n_first_arg;
    logic [4:0]        simple;
    logic [SLOT_W-1:0] slot_arg;
    logic [ROW_W-1:0]  save_row;

    // {hit, action} for single-command letters
    function automatic logic [4:0] f_simple(input logic [7:0] c);
        unique case (c)
            CH_H:     return {1'b1, ACT_HOME};
            CH_C:     return {1'b1, ACT_CLEAR};
            CH_X:     return {1'b1, ACT_OFF};
            CH_N:     return {1'b1, ACT_ON};
            CH_B:     return {1'b1, ACT_BLINK};
            CH_D:     return {1'b1, ACT_CURSOR};
            CH_E:     return {1'b1, ACT_CUR_BLINK};
            CH_MINUS: return {1'b1, ACT_LEFT};
            CH_PLUS:  return {1'b1, ACT_RIGHT};
            CH_LT:    return {1'b1, ACT_SHL};
            CH_GT:    return {1'b1, ACT_SHR};
            default:  return {1'b0, ACT_CHAR};
        endcase
    endfunction

    assign simple   = f_simple(i_rx_byte);
    assign slot_arg = SLOT_LUT[r_first_arg];
    assign save_row = ROW_W'(r_phase - PH_SAVE_ROW0);

    always_comb begin
        n_phase     = r_phase;
        n_first_arg = r_first_arg;
        o_cmd       = '0;
        o_wr        = '0;
        unique case (r_phase)
            PH_LETTER: begin
                if (simple[4]) begin
                    o_cmd.res    = 1'b1;
                    o_cmd.action = simple[3:0];
                    o_cmd.last   = 1'b1;
                    n_phase      = PH_TEXT;
                end else if (i_rx_byte == CH_L) begin
                    n_phase = PH_LOC_X;
                end else if (i_rx_byte == CH_M) begin
                    n_phase = PH_MAP_N;
                end else if (i_rx_byte == CH_S) begin
                    n_phase = PH_SAVE_N;
                end
            end
            PH_LOC_X: begin
                n_first_arg = i_rx_byte;
                n_phase     = PH_LOC_Y;
            end
            PH_LOC_Y: begin
                o_cmd.res    = 1'b1;
                o_cmd.action = ACT_LOCATE;
                o_cmd.arg_a  = r_first_arg;
                o_cmd.arg_b  = i_rx_byte;
                o_cmd.last   = 1'b1;
                n_phase      = PH_TEXT;
            end
            PH_MAP_N: begin
                n_first_arg = i_rx_byte;
                n_phase     = PH_MAP_K;
            end
            PH_MAP_K: begin
                o_cmd.res    = 1'b1;
                o_cmd.map    = 1'b1;
                o_cmd.action = ACT_GLYPH_ADDR;
                o_cmd.arg_a  = {5'd0, i_rx_byte[2:0]};
                o_cmd.slot   = slot_arg;
                n_phase      = PH_TEXT;
            end
            PH_SAVE_N: begin
                n_first_arg = i_rx_byte;
                n_phase     = PH_SAVE_ROW0;
            end
            PH_SAVE_ROW0, PH_SAVE_ROW1, PH_SAVE_ROW2, PH_SAVE_ROW3,
            PH_SAVE_ROW4, PH_SAVE_ROW5, PH_SAVE_ROW6, PH_SAVE_ROW7: begin
                o_wr.en   = i_accept;
                o_wr.addr = {slot_arg, save_row};
                o_wr.data = i_rx_byte;
                if (r_phase == PH_SAVE_ROW7) begin
                    o_wr.done    = 1'b1;
                    o_cmd.res    = 1'b1;
                    o_cmd.action = ACT_SAVED;
                    o_cmd.arg_a  = 8'(slot_arg);
                    o_cmd.last   = 1'b1;
                    n_phase      = PH_TEXT;
                end else begin
                    n_phase = r_phase + 4'd1;
                end
            end
            default: begin
                if (i_rx_byte == ESC_BYTE) begin
                    n_phase = PH_LETTER;
                end else begin
                    o_cmd.res    = 1'b1;
                    o_cmd.action = ACT_CHAR;
                    o_cmd.arg_a  = i_rx_byte;
                    o_cmd.last   = 1'b1;
                    n_phase      = PH_TEXT;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TEXT;
            r_first_arg <= 8'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_first_arg <= n_first_arg;
        end
    end

endmodule

// File: src/lcd_escape_command_parser.sv
// output: a result beat is registered in the cycle after its byte is accepted
// input: one byte per cycle unless the output stalls; a glyph map holds off input
// while its eight rows, one per unstalled cycle, come from the single store port
// reset: synchronous, active low; parser returns to text mode, the store reads
// the default glyphs again, output beat is dropped
module lcd_escape_command_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [3:0] o_action,
    output logic [7:0] o_arg_a,
    output logic [7:0] o_arg_b,
    output logic       o_last
);
    import lecp_pkg::*;

    t_cmd              cmd;
    t_wr               wr;
    logic [7:0]        rd_data;
    logic              in_accept;
    logic              out_free;
    logic              issue;
    logic              row_out;
    logic              row_last;
    logic [ADDR_W-1:0] rd_addr;

    logic              r_o_valid;
    logic              n_o_valid;
    logic              r_busy;
    logic              n_busy;
    logic              r_rd_pend;
    logic              n_rd_pend;
    logic [ROW_W:0]    r_req_row;
    logic [ROW_W:0]    n_req_row;
    logic [ROW_W-1:0]  r_out_row;
    logic [SLOT_W-1:0] r_slot;
    logic [3:0]        r_action;
    logic [7:0]        r_arg_a;
    logic [7:0]        r_arg_b;
    logic              r_last;

    assign out_free  = !r_o_valid || !i_stall;
    assign o_stall   = r_busy || !out_free;
    assign in_accept = i_valid && !o_stall;
    assign issue     = r_busy && (r_req_row < (ROW_W + 1)'(GLYPH_ROWS))
                       && (!r_rd_pend || out_free);
    assign row_out   = r_rd_pend && out_free;
    assign row_last  = r_out_row == ROW_W'(GLYPH_ROWS - 1);
    assign rd_addr   = {r_slot, r_req_row[ROW_W-1:0]};

    lecp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (in_accept),
        .i_rx_byte (i_rx_byte),
        .o_cmd     (cmd),
        .o_wr      (wr)
    );

    lecp_glyph_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_rd_en   (issue),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_busy    = r_busy;
        n_req_row = r_req_row;
        n_rd_pend = r_rd_pend;
        n_o_valid = r_o_valid;
        if (in_accept && cmd.map) begin
            n_busy    = 1'b1;
            n_req_row = '0;
        end
        if (issue) begin
            n_req_row = r_req_row + 1'b1;
            n_rd_pend = 1'b1;
        end else if (row_out) begin
            n_rd_pend = 1'b0;
        end
        if (row_out && row_last) begin
            n_busy = 1'b0;
        end
        if ((in_accept && cmd.res) || row_out) begin
            n_o_valid = 1'b1;
        end else if (!i_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_busy    <= 1'b0;
            r_rd_pend <= 1'b0;
            r_req_row <= '0;
        end else begin
            r_o_valid <= n_o_valid;
            r_busy    <= n_busy;
            r_rd_pend <= n_rd_pend;
            r_req_row <= n_req_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept && cmd.map) begin
            r_slot <= cmd.slot;
        end
        if (issue) begin
            r_out_row <= r_req_row[ROW_W-1:0];
        end
        if (in_accept && cmd.res) begin
            r_action <= cmd.action;
            r_arg_a  <= cmd.arg_a;
            r_arg_b  <= cmd.arg_b;
            r_last   <= cmd.last;
        end else if (row_out) begin
            r_action <= ACT_GLYPH_ROW;
            r_arg_a  <= rd_data;
            r_arg_b  <= 8'(r_out_row);
            r_last   <= row_last;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_action = r_action;
    assign o_arg_a  = r_arg_a;
    assign o_arg_b  = r_arg_b;
    assign o_last   = r_last;

    a_req_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_req_row <= (ROW_W + 1)'(GLYPH_ROWS))
        else $error("row request counter past glyph height");

    a_pend_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> r_busy)
        else $error("store read pending outside a glyph map");

    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !in_accept)
        else $error("byte taken during a glyph map");

    a_map_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(r_busy)) |->
            (o_valid && o_action == ACT_GLYPH_ROW && o_last))
        else $error("glyph map ended without its last row beat");

endmodule
